@@ design/length_prefixed_frame_parser_top_macros.svh @@
// assertion macros shared by the frame parser modules
`ifndef LENGTH_PREFIXED_FRAME_PARSER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked property, disabled while reset is high
`define LPFP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also checked during reset
`define LPFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPFP_ASSERT(lbl, clk, rst, prop, msg)
`define LPFP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/lpfp_pkg.sv @@
// shared types and constants for the length prefixed frame parser
`timescale 1ns / 1ps

package lpfp_pkg;

  localparam int LEN_CNT_BITS_DEFAULT = 24;
  localparam int MAX_LEN_BITS         = 24;
  localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 24'd65536;
  localparam logic [31:0] MIN_TOTAL_LEN = 32'd5;
  localparam logic [31:0] TYPE_BYTES    = 32'd4;

  typedef enum logic [3:0] {
    PH_LENGTH  = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_CONTENT = 4'b0100,
    PH_ERROR   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [31:0] packet_type;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last_of_packet;
    logic        header_error;
  } lpfp_result_t;

endpackage

@@ design/lpfp_parser.sv @@
// header collection, length check and content tagging, one beat per cycle
`timescale 1ns / 1ps

`include "length_prefixed_frame_parser_top_macros.svh"

module lpfp_parser #(
  parameter int LENGTH_COUNTER_BITS = lpfp_pkg::LEN_CNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                max_len_we,
  input  logic [lpfp_pkg::MAX_LEN_BITS-1:0]   max_len_wdata,
  input  logic                                in_fire,
  input  logic [7:0]                          in_byte,
  output logic                                res_valid,
  output lpfp_pkg::lpfp_result_t              res
);
  import lpfp_pkg::*;

  phase_t                         phase, phase_next;
  logic [1:0]                     hdr_idx, hdr_idx_next;
  logic [31:0]                    length_shift, length_shift_next;
  logic [31:0]                    type_shift, type_shift_next;
  logic [LENGTH_COUNTER_BITS-1:0] remaining, remaining_next;
  logic [MAX_LEN_BITS-1:0]        max_len;

  logic [31:0] len_new;
  logic [31:0] len_m4;
  logic        len_bad;
  logic        last;

  assign len_new = {in_byte, length_shift[31:8]};
  assign len_m4  = len_new - TYPE_BYTES;
  // negative, too short, above limit, or content count too wide for the counter
  assign len_bad = len_new[31] || (len_new < MIN_TOTAL_LEN) ||
                   (len_new > {{(32-MAX_LEN_BITS){1'b0}}, max_len}) ||
                   (len_m4[31:LENGTH_COUNTER_BITS] != '0);
  assign last = (remaining[LENGTH_COUNTER_BITS-1:1] == '0);

  always_comb begin
    phase_next        = phase;
    hdr_idx_next      = hdr_idx;
    length_shift_next = length_shift;
    type_shift_next   = type_shift;
    remaining_next    = remaining;
    res_valid         = 1'b0;
    res               = '0;
    if (in_fire) begin
      unique case (phase)
        PH_LENGTH: begin
          length_shift_next = len_new;
          hdr_idx_next      = hdr_idx + 2'd1;
          if (hdr_idx == 2'd3) begin
            if (len_bad) begin
              phase_next       = PH_ERROR;
              res_valid        = 1'b1;
              res.header_error = 1'b1;
            end else begin
              remaining_next = len_m4[LENGTH_COUNTER_BITS-1:0];
              phase_next     = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          type_shift_next = {in_byte, type_shift[31:8]};
          hdr_idx_next    = hdr_idx + 2'd1;
          if (hdr_idx == 2'd3) begin
            phase_next = PH_CONTENT;
          end
        end
        PH_CONTENT: begin
          res_valid          = 1'b1;
          res.packet_type    = type_shift;
          res.payload_byte   = in_byte;
          // a zero final byte is the terminator
          res.byte_valid     = !(last && (in_byte == 8'd0));
          res.last_of_packet = last;
          if (last) begin
            remaining_next = '0;
            phase_next     = PH_LENGTH;
            hdr_idx_next   = 2'd0;
          end else begin
            remaining_next = remaining - 1'b1;
          end
        end
        PH_ERROR: begin
          phase_next = PH_ERROR;
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LENGTH;
      hdr_idx      <= 2'd0;
      length_shift <= '0;
      type_shift   <= '0;
      remaining    <= '0;
      max_len      <= MAX_LEN_RESET;
    end else begin
      phase        <= phase_next;
      hdr_idx      <= hdr_idx_next;
      length_shift <= length_shift_next;
      type_shift   <= type_shift_next;
      remaining    <= remaining_next;
      if (max_len_we) begin
        max_len <= max_len_wdata;
      end
    end
  end

  `LPFP_ASSERT(a_error_silent, clk, rst, (in_fire && phase == PH_ERROR) |-> !res_valid, "result produced in error phase")
  `LPFP_ASSERT(a_error_sticky, clk, rst, (phase == PH_ERROR) |=> (phase == PH_ERROR), "left error phase without reset")
  `LPFP_ASSERT(a_err_on_len, clk, rst, (res_valid && res.header_error) |-> (phase == PH_LENGTH && hdr_idx == 2'd3), "header error outside last length byte")

endmodule

@@ design/lpfp_out_buf.sv @@
// output register with skid stage for result beats
`timescale 1ns / 1ps

`include "length_prefixed_frame_parser_top_macros.svh"

module lpfp_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lpfp_pkg::lpfp_result_t push_data,
  output logic                   room,
  output logic                   out_valid,
  output lpfp_pkg::lpfp_result_t out_data,
  input  logic                   out_ready
);
  import lpfp_pkg::*;

  lpfp_result_t out_q;
  lpfp_result_t skid_q;
  logic         out_v;
  logic         skid_v;
  logic         pop;

  assign pop       = out_v && out_ready;
  assign room      = !skid_v;
  assign out_valid = out_v;
  assign out_data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!out_v || pop) begin
        if (skid_v) begin
          out_v  <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          out_v <= push;
        end
      end else if (push) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || pop) begin
      out_q <= skid_v ? skid_q : push_data;
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  `LPFP_ASSERT(a_no_push_full, clk, rst, push |-> !skid_v, "push while skid stage holds a beat")
  `LPFP_ASSERT(a_skid_needs_out, clk, rst, skid_v |-> out_v, "skid beat held with empty output register")
  `LPFP_ASSERT(a_skid_drains, clk, rst, (skid_v && pop) |=> (out_v && !skid_v), "skid beat not moved on pop")

endmodule

@@ design/length_prefixed_frame_parser_top.sv @@
// top level of the length prefixed frame parser
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata[7:0] data_byte
//  m_*       out  m_tvalid/m_tready    tdata[39:0], tlast, tuser[1:0]
//  max_len   in   max_len_we           max_len_wdata[23:0] max_total_length
//
// one input beat per cycle while s_tready is high; each result is registered
// header bytes give no result but a header error, each content byte gives one
// reset (rst, synchronous) restores the length phase and a 65536 limit
// a stalled output fills the skid stage, then s_tready drops
// after a header error every beat is taken and dropped until reset
`timescale 1ns / 1ps

module length_prefixed_frame_parser_top #(
  parameter int LENGTH_COUNTER_BITS = lpfp_pkg::LEN_CNT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              max_len_we,
  input  logic [lpfp_pkg::MAX_LEN_BITS-1:0] max_len_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // data_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,  // packet_type, payload_byte
  output logic                              m_tlast,  // last_of_packet
  output logic [1:0]                        m_tuser   // byte_valid, header_error
);
  import lpfp_pkg::*;

  logic         in_fire;
  logic         res_valid;
  lpfp_result_t res;
  lpfp_result_t out_res;

  assign in_fire = s_tvalid && s_tready;

  lpfp_parser #(
    .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .max_len_we    (max_len_we),
    .max_len_wdata (max_len_wdata),
    .in_fire       (in_fire),
    .in_byte       (s_tdata),
    .res_valid     (res_valid),
    .res           (res)
  );

  lpfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {out_res.payload_byte, out_res.packet_type};
  assign m_tlast = out_res.last_of_packet;
  assign m_tuser = {out_res.header_error, out_res.byte_valid};

endmodule
